/* hdl/whmc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the word mix hash combiner
// used by the front pipeline, queue, back end and top level
package whmc_pkg;

  localparam logic [31:0] MIX_MULT   = 32'h045d9f3b;
  localparam logic [31:0] GOLDEN_ADD = 32'h9e3779b9;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  // register index is paddr[3] (8-byte register spacing)
  localparam logic [0:0] REG_SEED = 1'b0;

  // one classified and mixed word on its way to the combine step
  typedef struct packed {
    logic [31:0] mix_sum;
    logic        nonzero;
    logic        last;
  } whmc_item_t;

endpackage

/* hdl/word_mix_hash_combine.sv */
`timescale 1ns / 1ps
// word mix hash combiner
// throughput is one word per cycle while in_stall and out_stall are low; the three-stage mix
// pipeline and the combine step run at one word per cycle, an 8-entry queue decouples them
// synchronous active-low reset clears the seed to 0 and starts a fresh message
// depends on whmc_pkg, whmc_front, whmc_fifo, whmc_back
module word_mix_hash_combine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] seed_r, seed_nxt;
  logic        seed_wr;
  logic        push, pop, empty;
  whmc_pkg::whmc_item_t push_item, head;
  logic [whmc_pkg::FIFO_CW-1:0] fifo_cnt;

  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[3] == whmc_pkg::REG_SEED);
  assign seed_nxt = seed_wr ? pwdata : seed_r;
  assign prdata  = (paddr[3] == whmc_pkg::REG_SEED) ? seed_r : 64'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'h0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  whmc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .fifo_cnt       (fifo_cnt),
    .push           (push),
    .push_item      (push_item)
  );

  whmc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .cnt       (fifo_cnt)
  );

  whmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed      (seed_r),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hash  (out_hash)
  );

endmodule

/* hdl/whmc_front.sv */
`timescale 1ns / 1ps
// front end: accepts words, masks invalid bytes and runs the mix rounds
// depends on whmc_pkg; pushes finished items into whmc_fifo
module whmc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_word,
  input  logic [2:0]                    in_valid_bytes,
  input  logic                          in_last,
  input  logic [whmc_pkg::FIFO_CW-1:0]  fifo_cnt,
  output logic                          push,
  output whmc_pkg::whmc_item_t          push_item
);

  logic        a_v_r, b_v_r, c_v_r;
  logic        a_v_nxt, b_v_nxt, c_v_nxt;
  logic [31:0] a_w_r, a_w_nxt;
  logic [31:0] b_p_r, b_p_nxt;
  logic [31:0] c_p_r, c_p_nxt;
  logic [1:0]  a_f_r, b_f_r, c_f_r;  // {nonzero, last}
  logic [1:0]  a_f_nxt;
  logic [31:0] masked;
  logic [31:0] b_x, c_x, d_x;
  logic [whmc_pkg::FIFO_CW:0] used;
  logic        accept;

  // credit check: every item in flight already owns a queue slot
  assign used = {1'b0, fifo_cnt} + (whmc_pkg::FIFO_CW+1)'(a_v_r)
              + (whmc_pkg::FIFO_CW+1)'(b_v_r) + (whmc_pkg::FIFO_CW+1)'(c_v_r);
  assign in_stall = (used >= (whmc_pkg::FIFO_CW+1)'(whmc_pkg::FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      masked[8*i +: 8] = (in_valid_bytes > 3'(i)) ? in_word[8*i +: 8] : 8'h00;
    end
  end

  assign a_w_nxt = masked;
  assign a_f_nxt = {(in_valid_bytes != 3'd0), in_last};
  assign a_v_nxt = accept;

  assign b_x     = a_w_r ^ (a_w_r >> 16);
  assign b_p_nxt = b_x * whmc_pkg::MIX_MULT;
  assign b_v_nxt = a_v_r;

  assign c_x     = b_p_r ^ (b_p_r >> 16);
  assign c_p_nxt = c_x * whmc_pkg::MIX_MULT;
  assign c_v_nxt = b_v_r;

  assign d_x = c_p_r ^ (c_p_r >> 16);
  assign push              = c_v_r;
  assign push_item.mix_sum = d_x + whmc_pkg::GOLDEN_ADD;
  assign push_item.nonzero = c_f_r[1];
  assign push_item.last    = c_f_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      c_v_r <= c_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_w_r <= a_w_nxt;
      a_f_r <= a_f_nxt;
    end
    b_p_r <= b_p_nxt;
    b_f_r <= a_f_r;
    c_p_r <= c_p_nxt;
    c_f_r <= b_f_r;
  end

endmodule

/* hdl/whmc_fifo.sv */
`timescale 1ns / 1ps
// short queue between the mix pipeline and the combine step
// depends on whmc_pkg for depth and item type
module whmc_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  whmc_pkg::whmc_item_t          push_item,
  input  logic                          pop,
  output whmc_pkg::whmc_item_t          head,
  output logic                          empty,
  output logic [whmc_pkg::FIFO_CW-1:0]  cnt
);

  whmc_pkg::whmc_item_t mem [whmc_pkg::FIFO_DEPTH];
  whmc_pkg::whmc_item_t head_r;
  logic [whmc_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [whmc_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [whmc_pkg::FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign head  = head_r;
  assign empty = (cnt_r == '0);
  assign cnt   = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + whmc_pkg::FIFO_CW'(push) - whmc_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // head register tracks the next read slot, bypassing a word written into it
  always_ff @(posedge clk) begin
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_item;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

/* hdl/whmc_back.sv */
`timescale 1ns / 1ps
// back end: folds mixed words into the running hash and holds the result
// depends on whmc_pkg; pops items from whmc_fifo
module whmc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [63:0]          seed,
  input  whmc_pkg::whmc_item_t head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_hash
);

  logic        at_start_r, at_start_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r;
  logic [63:0] h_in, h_mix, h_new;

  assign pop = !empty && (!out_valid_r || !out_stall);

  // the new seed takes effect on the first word of a message
  assign h_in  = at_start_r ? seed : hash_r;
  assign h_mix = h_in ^ ({32'h0, head.mix_sum} + (h_in << 6) + (h_in >> 2));
  assign h_new = head.nonzero ? h_mix : h_in;

  always_comb begin
    at_start_nxt  = at_start_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      hash_nxt     = h_new;
      at_start_nxt = head.last;
      if (head.last) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      at_start_r  <= at_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    if (pop && head.last) begin
      out_hash_r <= h_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

endmodule

/* hdl/whmc_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the word mix hash combiner
// depends on word_mix_hash_combine ports; attached by the bind below
module whmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_hash,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata,
  input logic        pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hash))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

  // seed read back right after a write
  a_seed_rd: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(psel && penable && pwrite && !paddr[3])
      && psel && penable && !pwrite && !paddr[3]
    |-> prdata == $past(pwdata))
    else $error("seed readback mismatch");

endmodule

bind word_mix_hash_combine whmc_checker u_whmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_hash  (out_hash),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
